[rtl/core/bilinear_texture_sampler_wrap_macros.svh]
// Assertion helpers for the texture sampler. Both expect clk_i and rst_ni
// to be visible where they are used.
`ifndef BILINEAR_TEXTURE_SAMPLER_WRAP_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_WRAP_MACROS_SVH

// Same-cycle implication.
`define BTS_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("bts: same-cycle check failed");

// Next-cycle implication.
`define BTS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("bts: next-cycle check failed");

`endif

[rtl/core/bts_pkg.sv]
package bts_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W   = 24;
  localparam int CH_W      = 16;
  localparam int DIM_REG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CH_W-1:0] CH_MAX = 16'hFF00;

  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic MODE_GRAY = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [CH_W-1:0]           red_in;
    logic [CH_W-1:0]           green_in;
    logic [CH_W-1:0]           blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_item_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W+1:0] v);
    return (v > {2'b00, CH_MAX}) ? CH_MAX : v[CH_W-1:0];
  endfunction

endpackage

[rtl/core/bts_if.sv]
interface bts_in_if;
  logic               valid;
  logic               ready;
  bts_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bts_out_if;
  logic               valid;
  logic               ready;
  bts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bts_pkg::CFG_IDX_W-1:0]     index;
  logic [bts_pkg::DIM_REG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/bts_wrap.sv]
// Signed integer modulo an unsigned modulus, remainder moved into [0, mod).
// Restoring division, one quotient bit per cycle.
module bts_wrap #(
  parameter int IW = 16,
  parameter int MW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [IW-1:0] value_i,
  input  logic [MW-1:0]        mod_i,
  output logic                 done_o,
  output logic [MW-1:0]        result_o
);

  localparam int CW = $clog2(IW + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] mag_q;
  logic [MW-1:0] rem_q;
  logic [MW:0]   trial;
  logic [MW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, mag_q[IW-1]};
    if (trial >= {1'b0, mod_i}) begin
      rem_d = MW'(trial - {1'b0, mod_i});
    end else begin
      rem_d = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(IW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= value_i[IW-1];
      mag_q <= value_i[IW-1] ? -value_i : value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[IW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = (neg_q && rem_q != '0) ? MW'(mod_i - rem_q) : rem_q;

endmodule

[rtl/core/bilinear_texture_sampler_wrap.sv]
// Channel  Dir  Handshake     Payload
// -------  ---  ------------  ----------------------------------------------
// cfg_i    in   valid/ready   index (0 width, 1 height, 2 mode), data
// in_i     in   valid/ready   action, coord_x, coord_y, red/green/blue_in
// out_o    out  valid/ready   red_out, green_out, blue_out (samples only)
//
// After reset the texture memory is swept to zero, one texel a cycle, and
// in_i is held off meanwhile. One item at a time: coordinate wrap computes
// one remainder bit a cycle, then raises the done flag; then a write stores
// its texel, and a sample makes four reads of the single-port memory, then
// drains and loads the output register. cfg_i is always ready.
// A result waiting in the output register does not block the next item
// until that item's own result is due.
module bilinear_texture_sampler_wrap #(
  parameter int MAX_WIDTH       = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = bts_pkg::MAX_HEIGHT_DEF,
  parameter int COORD_FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bts_cfg_if.sink   cfg_i,
  bts_in_if.sink    in_i,
  bts_out_if.source out_o
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int IW     = bts_pkg::COORD_W - F;
  localparam int DWX    = $clog2(MAX_WIDTH + 1);
  localparam int DWY    = $clog2(MAX_HEIGHT + 1);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CHW    = bts_pkg::CH_W;
  localparam int WGW    = 2 * F + 2;
  localparam int PW     = CHW + WGW;
  localparam int AW     = PW + 2;
  localparam int LW     = 34;

  localparam logic [F:0]    S_VAL = (F+1)'(1 << F);
  localparam logic [AW-1:0] HALF  = AW'(1) << (2 * F - 1);

  // Configuration registers, kept as written.
  logic [bts_pkg::DIM_REG_W-1:0] width_q, height_q;
  logic                          mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bts_pkg::DIM_REG_W'(1);
      height_q <= bts_pkg::DIM_REG_W'(1);
      mode_q   <= bts_pkg::MODE_GRAY;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bts_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_i.data;
        bts_pkg::CFG_IDX_HEIGHT: height_q <= cfg_i.data;
        bts_pkg::CFG_IDX_MODE:   mode_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, oversize acts as the maximum.
  logic [DWX-1:0] w_eff;
  logic [DWY-1:0] h_eff;

  always_comb begin
    if (width_q == '0) w_eff = DWX'(1);
    else if (int'(width_q) > MAX_WIDTH) w_eff = DWX'(MAX_WIDTH);
    else w_eff = DWX'(width_q);
    if (height_q == '0) h_eff = DWY'(1);
    else if (int'(height_q) > MAX_HEIGHT) h_eff = DWY'(MAX_HEIGHT);
    else h_eff = DWY'(height_q);
  end

  // Control
  bts_pkg::state_e state_q, state_d;
  bts_pkg::in_item_t in_q;
  logic [ADDRW-1:0] clr_q;
  logic [1:0]       idx_q;
  logic             rd_vld_q;
  logic             out_vld_q;
  bts_pkg::out_item_t out_q;

  logic in_acc, out_load;
  assign in_acc = in_i.valid && in_i.ready;

  // Wrap units, one per axis; both finish in the same cycle.
  logic           wx_done, wy_done;
  logic [DWX-1:0] wx_res;
  logic [DWY-1:0] wy_res;

  bts_wrap #(.IW(IW), .MW(DWX)) u_wrap_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .value_i  (in_i.data.coord_x[bts_pkg::COORD_W-1:F]),
    .mod_i    (w_eff),
    .done_o   (wx_done),
    .result_o (wx_res)
  );

  bts_wrap #(.IW(IW), .MW(DWY)) u_wrap_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .value_i  (in_i.data.coord_y[bts_pkg::COORD_W-1:F]),
    .mod_i    (h_eff),
    .done_o   (wy_done),
    .result_o (wy_res)
  );

  // Far neighbor: step by one and wrap, unless the fraction is zero.
  logic [F-1:0]   fx, fy;
  logic [DWX-1:0] x_inc;
  logic [DWY-1:0] y_inc;
  logic [XW-1:0]  x0_q, x1_q;
  logic [YW-1:0]  y0_q, y1_q;

  assign fx    = in_q.coord_x[F-1:0];
  assign fy    = in_q.coord_y[F-1:0];
  assign x_inc = wx_res + 1'b1;
  assign y_inc = wy_res + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wx_done && wy_done) begin
      x0_q <= XW'(wx_res);
      x1_q <= (fx == '0) ? XW'(wx_res) : ((x_inc == w_eff) ? '0 : XW'(x_inc));
      y0_q <= YW'(wy_res);
      y1_q <= (fy == '0) ? YW'(wy_res) : ((y_inc == h_eff) ? '0 : YW'(y_inc));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_i.data;
  end

  // Luma products, held while the wrap runs.
  logic [31:0] lr_q, lg_q, lb_q;
  logic [LW-1:0] luma_sum;
  logic [CHW+1:0] luma;

  always_ff @(posedge clk_i) begin
    lr_q <= in_q.red_in   * bts_pkg::LUMA_R;
    lg_q <= in_q.green_in * bts_pkg::LUMA_G;
    lb_q <= in_q.blue_in  * bts_pkg::LUMA_B;
  end

  assign luma_sum = LW'(lr_q) + LW'(lg_q) + LW'(lb_q) + LW'(32768);
  assign luma     = luma_sum[LW-1:16];

  // Texture memory: red lane and green/blue lane, one shared address port.
  logic [CHW-1:0]   mem_r  [DEPTH];
  logic [2*CHW-1:0] mem_gb [DEPTH];
  logic [ADDRW-1:0] mem_addr;
  logic             we_r, we_gb;
  logic [CHW-1:0]   wd_r, wd_g, wd_b;
  logic [CHW-1:0]   rd_r_q, rd_g_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_r) mem_r[mem_addr] <= wd_r;
    if (we_gb) mem_gb[mem_addr] <= {wd_g, wd_b};
    rd_r_q <= mem_r[mem_addr];
    {rd_g_q, rd_b_q} <= mem_gb[mem_addr];
  end

  // Neighbor select and blend weight for the current read.
  logic [XW-1:0]   sel_x;
  logic [YW-1:0]   sel_y;
  logic [F:0]      fa, fb;
  logic [WGW-1:0]  wgt_q;
  logic [ADDRW-1:0] rd_addr, wr_addr;

  assign sel_x   = idx_q[0] ? x1_q : x0_q;
  assign sel_y   = idx_q[1] ? y1_q : y0_q;
  assign fa      = idx_q[0] ? {1'b0, fx} : S_VAL - {1'b0, fx};
  assign fb      = idx_q[1] ? {1'b0, fy} : S_VAL - {1'b0, fy};
  assign rd_addr = ADDRW'(sel_y) * ADDRW'(MAX_WIDTH) + ADDRW'(sel_x);
  assign wr_addr = ADDRW'(y0_q) * ADDRW'(MAX_WIDTH) + ADDRW'(x0_q);

  always_ff @(posedge clk_i) begin
    wgt_q <= WGW'(fa * fb);
  end

  // Accumulate each channel as its neighbor's data returns.
  logic [AW-1:0] acc_r_q, acc_g_q, acc_b_q;
  logic [AW-1:0] rnd_r, rnd_g, rnd_b;

  always_ff @(posedge clk_i) begin
    if (state_q == bts_pkg::ST_WRAP) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (rd_vld_q) begin
      acc_r_q <= acc_r_q + AW'(rd_r_q * wgt_q);
      acc_g_q <= acc_g_q + AW'(rd_g_q * wgt_q);
      acc_b_q <= acc_b_q + AW'(rd_b_q * wgt_q);
    end
  end

  assign rnd_r = acc_r_q + HALF;
  assign rnd_g = acc_g_q + HALF;
  assign rnd_b = acc_b_q + HALF;

  // Next state and datapath controls.
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    mem_addr   = rd_addr;
    we_r       = 1'b0;
    we_gb      = 1'b0;
    wd_r       = '0;
    wd_g       = '0;
    wd_b       = '0;
    out_load   = 1'b0;
    unique case (state_q)
      bts_pkg::ST_CLEAR: begin
        mem_addr = clr_q;
        we_r     = 1'b1;
        we_gb    = 1'b1;
        if (clr_q == ADDRW'(DEPTH - 1)) state_d = bts_pkg::ST_IDLE;
      end
      bts_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = bts_pkg::ST_WRAP;
      end
      bts_pkg::ST_WRAP: begin
        if (wx_done && wy_done) begin
          state_d = (in_q.action == bts_pkg::ACT_WRITE) ? bts_pkg::ST_WRITE
                                                        : bts_pkg::ST_READ;
        end
      end
      bts_pkg::ST_WRITE: begin
        mem_addr = wr_addr;
        we_r     = 1'b1;
        we_gb    = mode_q;
        wd_r     = mode_q ? bts_pkg::clamp_ch({2'b00, in_q.red_in})
                          : bts_pkg::clamp_ch(luma);
        wd_g     = bts_pkg::clamp_ch({2'b00, in_q.green_in});
        wd_b     = bts_pkg::clamp_ch({2'b00, in_q.blue_in});
        state_d  = bts_pkg::ST_IDLE;
      end
      bts_pkg::ST_READ: begin
        if (idx_q == 2'd3) state_d = bts_pkg::ST_DRAIN;
      end
      bts_pkg::ST_DRAIN: begin
        state_d = bts_pkg::ST_DONE;
      end
      bts_pkg::ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = bts_pkg::ST_IDLE;
        end
      end
      default: state_d = bts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bts_pkg::ST_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == bts_pkg::ST_READ);
      if (state_q == bts_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == bts_pkg::ST_READ) idx_q <= idx_q + 1'b1;
      else idx_q <= '0;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Result register; gray mode copies the red slot to all three outputs.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.red_out   <= rnd_r[2*F +: CHW];
      out_q.green_out <= (mode_q == bts_pkg::MODE_GRAY) ? rnd_r[2*F +: CHW]
                                                        : rnd_g[2*F +: CHW];
      out_q.blue_out  <= (mode_q == bts_pkg::MODE_GRAY) ? rnd_r[2*F +: CHW]
                                                        : rnd_b[2*F +: CHW];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

[rtl/core/bts_chk.sv]
`include "bilinear_texture_sampler_wrap_macros.svh"

module bts_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bts_pkg::out_item_t out_data_i
);

  // Memory sweep holds off input right after reset.
  `BTS_ASSERT_NOW(a_clear_holds_input, $rose(rst_ni), !in_ready_i)
  // One item in flight: accept drops ready.
  `BTS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)
  // A new result appears only while input was held off.
  `BTS_ASSERT_NOW(a_result_while_busy, $rose(out_valid_i), $past(!in_ready_i))
  // Stalled result holds.
  `BTS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_data_i))

endmodule

bind bilinear_texture_sampler_wrap bts_chk u_bts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

[tb/sv/bilinear_texture_sampler_wrap_tb.sv]
module bilinear_texture_sampler_wrap_tb;

  localparam int TEX_W_MAX = 64;
  localparam int TEX_H_MAX = 64;
  localparam int FRAC      = 8;
  localparam int WRITE_LAT = 40;

  // Texture store and predictor: mirrors the block's texel memory and settings,
  // and holds the expected samples in arrival order.
  class texel_predictor;
    logic [15:0] texels [TEX_W_MAX*TEX_H_MAX][3];
    logic [6:0]  width_reg, height_reg;
    logic        rgb_mode;
    bts_pkg::out_item_t pending_samples [$];
    int          errors;
    int          checked;

    function void clear_all();
      foreach (texels[a]) begin
        texels[a][0] = '0;
        texels[a][1] = '0;
        texels[a][2] = '0;
      end
      width_reg = 7'd1;
      height_reg = 7'd1;
      rgb_mode = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [6:0] v);
      case (idx)
        bts_pkg::CFG_IDX_WIDTH: width_reg = v;
        bts_pkg::CFG_IDX_HEIGHT: height_reg = v;
        bts_pkg::CFG_IDX_MODE: rgb_mode = v[0];
        default: ;
      endcase
    endfunction

    function int dim_of(logic [6:0] r, int maxv);
      if (r == 0) return 1;
      if (r > maxv) return maxv;
      return r;
    endfunction

    function int wrap_to(int i, int m);
      int r;
      r = i % m;
      if (r < 0) r += m;
      return r;
    endfunction

    function logic [15:0] limit(longint v);
      return (v > 65280) ? 16'hFF00 : v[15:0];
    endfunction

    // Note an accepted input item; a sample queues its expected color.
    function void note_input(bts_pkg::in_item_t it);
      int w, h, ix, iy, fx, fy, x0, x1, y0, y1, a00, a10, a01, a11, nch;
      longint w00, w10, w01, w11, acc, l;
      bts_pkg::out_item_t e;
      logic [15:0] res [3];
      w = dim_of(width_reg, TEX_W_MAX);
      h = dim_of(height_reg, TEX_H_MAX);
      fx = it.coord_x[FRAC-1:0];
      fy = it.coord_y[FRAC-1:0];
      ix = int'(it.coord_x) >>> FRAC;
      iy = int'(it.coord_y) >>> FRAC;
      if (it.action == bts_pkg::ACT_WRITE) begin
        a00 = wrap_to(iy, h) * TEX_W_MAX + wrap_to(ix, w);
        if (rgb_mode) begin
          texels[a00][0] = limit(it.red_in);
          texels[a00][1] = limit(it.green_in);
          texels[a00][2] = limit(it.blue_in);
        end else begin
          l = (longint'(19595) * it.red_in + longint'(38470) * it.green_in
               + longint'(7471) * it.blue_in + 32768) >>> 16;
          texels[a00][0] = limit(l);
        end
        return;
      end
      x0 = wrap_to(ix, w);
      x1 = wrap_to(ix + (fx != 0), w);
      y0 = wrap_to(iy, h);
      y1 = wrap_to(iy + (fy != 0), h);
      a00 = y0 * TEX_W_MAX + x0;
      a10 = y0 * TEX_W_MAX + x1;
      a01 = y1 * TEX_W_MAX + x0;
      a11 = y1 * TEX_W_MAX + x1;
      w00 = (256 - fx) * (256 - fy);
      w10 = fx * (256 - fy);
      w01 = (256 - fx) * fy;
      w11 = fx * fy;
      nch = rgb_mode ? 3 : 1;
      for (int c = 0; c < nch; c++) begin
        acc = texels[a00][c] * w00 + texels[a10][c] * w10
            + texels[a01][c] * w01 + texels[a11][c] * w11;
        res[c] = 16'((acc + 32768) >> (2 * FRAC));
      end
      if (nch == 1) begin
        res[1] = res[0];
        res[2] = res[0];
      end
      e.red_out = res[0];
      e.green_out = res[1];
      e.blue_out = res[2];
      pending_samples.push_back(e);
    endfunction

    // Compare one returned sample with the oldest expected one.
    function void check_sample(bts_pkg::out_item_t got);
      bts_pkg::out_item_t e;
      checked++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample exp none act %h", $time, got);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (got.red_out !== e.red_out) begin
        $display("%0t: red mismatch exp %h act %h", $time, e.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== e.green_out) begin
        $display("%0t: green mismatch exp %h act %h", $time, e.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== e.blue_out) begin
        $display("%0t: blue mismatch exp %h act %h", $time, e.blue_out, got.blue_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet_tail = 1'b0;
  int   n_writes = 0, n_samples = 0;

  bts_cfg_if cfg_ch ();
  bts_in_if  in_ch ();
  bts_out_if out_ch ();

  texel_predictor tex_model = new();

  bilinear_texture_sampler_wrap DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop: reset sweep plus ~2000 items with stalls.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: sample every accepted result at the rising edge, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) tex_model.check_sample(out_ch.data);
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Write one register while the block is idle.
  task automatic write_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [6:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tex_model.set_reg(idx, v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain: wait until every sample has come back, then let a write finish.
  task automatic settle();
    while (tex_model.pending_samples.size() != 0) @(negedge clk_i);
    repeat (WRITE_LAT) @(negedge clk_i);
  endtask

  task automatic set_shape(logic [6:0] w, logic [6:0] h, logic m);
    settle();
    write_reg(bts_pkg::CFG_IDX_WIDTH, w);
    write_reg(bts_pkg::CFG_IDX_HEIGHT, h);
    write_reg(bts_pkg::CFG_IDX_MODE, {6'd0, m});
  endtask

  // Send one item after an occasional random idle gap; otherwise valid stays high across back-to-back items.
  task automatic send_item(bts_pkg::in_item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    tex_model.note_input(it);
    if (it.action == bts_pkg::ACT_WRITE) n_writes++;
    else n_samples++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic bts_pkg::in_item_t make_item(logic act, int x, int y,
                                         logic [15:0] r, logic [15:0] g, logic [15:0] b);
    bts_pkg::in_item_t it;
    it.action = act;
    it.coord_x = 24'(x);
    it.coord_y = 24'(y);
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    return it;
  endfunction

  // Random item: mostly coordinates near the texture, sometimes full range;
  // channels sometimes above the clamp point.
  function automatic bts_pkg::in_item_t rand_item(int w, int h, int wr_pct);
    int x, y;
    logic [15:0] ch [3];
    if ($urandom_range(0, 9) == 0) begin
      x = $signed($urandom() & 24'hFFFFFF) <<< 8 >>> 8;
      y = $signed($urandom() & 24'hFFFFFF) <<< 8 >>> 8;
    end else begin
      x = $signed($urandom_range(0, 6 * w * 256)) - 3 * w * 256;
      y = $signed($urandom_range(0, 6 * h * 256)) - 3 * h * 256;
    end
    x = (x << 8) >>> 8;
    y = (y << 8) >>> 8;
    if ($urandom_range(0, 3) == 0) x &= ~32'hFF;
    foreach (ch[i]) ch[i] = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                              16'($urandom_range(0, 65280));
    return make_item($urandom_range(0, 99) < wr_pct ? bts_pkg::ACT_WRITE
                                                     : bts_pkg::ACT_SAMPLE,
                     x, y, ch[0], ch[1], ch[2]);
  endfunction

  initial begin
    int w, h;
    tex_model.clear_all();
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bts_pkg::CFG_IDX_WIDTH;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset store read, gray and RGB writes, clamps, extremes, sizes 0 and 127.
    send_item(make_item(bts_pkg::ACT_SAMPLE, 0, 0, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_WRITE, 24'h7FFFFF, 24'h800000,
                        16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 24'h800000, 24'h7FFFFF, 0, 0, 0));
    stop_sending();
    set_shape(7'd4, 7'd3, 1'b1);
    send_item(make_item(bts_pkg::ACT_WRITE, 0, 0, 16'hFF00, 16'hFF01, 16'h0000));
    send_item(make_item(bts_pkg::ACT_WRITE, 256, 0, 16'h0100, 16'h8000, 16'hFFFF));
    send_item(make_item(bts_pkg::ACT_WRITE, -256, -1, 16'h1234, 16'h5678, 16'h9ABC));
    send_item(make_item(bts_pkg::ACT_WRITE, 3 * 256, 256, 16'hAAAA, 16'h5555, 16'h00FF));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 128, 128, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 256, 0, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_SAMPLE, -1, -1, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 3 * 256 + 255, 2 * 256 + 1, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 24'h7FFFFF, 24'h800000, 0, 0, 0));
    stop_sending();
    set_shape(7'd0, 7'd127, 1'b0);
    send_item(make_item(bts_pkg::ACT_WRITE, 5 * 256, 63 * 256,
                        16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(bts_pkg::ACT_WRITE, 0, 64 * 256, 16'h8000, 16'h0000, 16'h0000));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 77, 63 * 256 + 200, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_SAMPLE, 0, -128, 0, 0, 0));
    stop_sending();
    set_shape(7'd64, 7'd64, 1'b1);
    send_item(make_item(bts_pkg::ACT_SAMPLE, 63 * 256 + 128, 63 * 256 + 128, 0, 0, 0));
    send_item(make_item(bts_pkg::ACT_WRITE, 63 * 256, 0, 16'h0001, 16'h0002, 16'h0003));
    send_item(make_item(bts_pkg::ACT_SAMPLE, -128, 255, 0, 0, 0));
    // Hold off until every expected sample has come back.
    stop_sending();
    while (tex_model.pending_samples.size() != 0) @(negedge clk_i);

    // Random phases: several shapes and both modes, extremes included.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin w = 1; h = 1; end
        1: begin w = 64; h = 64; end
        2: begin w = 127; h = 0; end
        3: begin w = 2; h = 64; end
        default: begin w = $urandom_range(0, 127); h = $urandom_range(0, 127); end
      endcase
      if (ph == 12) quiet_tail = 1'b1;
      set_shape(w[6:0], h[6:0], ph[0]);
      w = tex_model.dim_of(w[6:0], TEX_W_MAX);
      h = tex_model.dim_of(h[6:0], TEX_H_MAX);
      for (int k = 0; k < 125; k++) send_item(rand_item(w, h, (k < 40) ? 70 : 40));
      stop_sending();
    end

    settle();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d writes and %0d samples (%0d checked) over 17 shapes in both modes.",
             n_writes, n_samples, tex_model.checked);
    if (tex_model.errors == 0 && tex_model.pending_samples.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
